// ----- rtl/scaled_bitmap_glyph_renderer_macros.svh -----
// ----------------------------------------------------------------------------
// Assertion macros for the scaled bitmap glyph renderer
// Concurrent checks that compile away when SYNTHESIS is defined.
// ----------------------------------------------------------------------------
`ifndef SCALED_BITMAP_GLYPH_RENDERER_MACROS_SVH
`define SCALED_BITMAP_GLYPH_RENDERER_MACROS_SVH

`ifndef SYNTHESIS

// same-cycle implication, checked out of reset
`define SBGR_ASSERT_IMP(name, clk, rstn, ante, cons) \
    name: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |-> (cons)) \
        else $error("sbgr assertion failed");

// next-cycle implication, checked out of reset
`define SBGR_ASSERT_NXT(name, clk, rstn, ante, cons) \
    name: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |=> (cons)) \
        else $error("sbgr assertion failed");

`else

`define SBGR_ASSERT_IMP(name, clk, rstn, ante, cons)
`define SBGR_ASSERT_NXT(name, clk, rstn, ante, cons)

`endif

`endif

// ----- rtl/sbgr_pkg.sv -----
// ----------------------------------------------------------------------------
// sbgr_pkg
// Shared constants and codes of the scaled bitmap glyph renderer.
// ----------------------------------------------------------------------------
`default_nettype none

package sbgr_pkg;

    // parameter defaults
    localparam int FONT_CHARS_DEF       = 256;
    localparam int MAX_X_SCALE_DEF      = 10;
    localparam int BUFFER_ADDR_BITS_DEF = 16;

    // fixed glyph geometry
    localparam int GLYPH_ROWS     = 8;
    localparam int GLYPH_ROW_BITS = 3;
    localparam int FONT_BYTE_W    = 8;

    // field widths
    localparam int XS_W      = 4;
    localparam int YS_W      = 5;
    localparam int LINE_W    = 10;
    localparam int CFG_W     = 10;
    localparam int CFG_IDX_W = 2;
    localparam int OUT_ADDR_W = 16;

    // internal address arithmetic
    localparam int LINE_IDX_W = 8;   // glyph_row*y_scale + copy_row
    localparam int COL_TERM_W = 12;  // column*x_scale
    localparam int BASE_W     = 19;  // full unwrapped base address

    // configuration register indexes
    localparam logic [CFG_IDX_W-1:0] CFG_X_SCALE       = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_Y_SCALE       = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_LINE_STRIDE   = 2'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_COLUMN_OFFSET = 2'd3;

    // item kinds
    localparam logic KIND_LOAD   = 1'b0;
    localparam logic KIND_RENDER = 1'b1;

endpackage

`default_nettype wire

// ----- rtl/sbgr_ram.sv -----
// ----------------------------------------------------------------------------
// sbgr_ram
// Generic single-port RAM, one access per cycle, registered read.
// ----------------------------------------------------------------------------
`default_nettype none

module sbgr_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 2048
) (
    input  wire logic                     clk,
    input  wire logic                     we,
    input  wire logic                     re,
    input  wire logic [$clog2(DEPTH)-1:0] addr,
    input  wire logic [WIDTH-1:0]         wdata,
    output logic      [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[addr] <= wdata;
        end
        if (re)
        begin
            rdata <= mem[addr];
        end
    end

endmodule

`default_nettype wire

// ----- rtl/scaled_bitmap_glyph_renderer.sv -----
// ----------------------------------------------------------------------------
// scaled_bitmap_glyph_renderer
// 8x8 font memory plus a row renderer that stretches one glyph row by
// x_scale and emits the bytes with their frame-buffer addresses.
// ----------------------------------------------------------------------------
//
//  channel   direction  handshake              payload
//  -------   ---------  ---------------------  ----------------------------------
//  in        sink       in_valid / in_stall    kind, font_address, font_data,
//                                              char_code, glyph_row, copy_row,
//                                              column
//  out       source     out_valid / out_stall  buffer_address, pixel_byte, last
//  cfg       sink       cfg_write              cfg_index, cfg_data
//
//  A load transaction writes the font RAM in its accept cycle and yields nothing.
//  A render transaction with copy_row below y_scale and nonzero x_scale gives
//  x_scale output transactions, one per cycle unless out_stall holds them; the
//  byte emitter sets that rate while s1 and s2 already take the next items.
//  out_valid rises after the s1, s2 (base address), emitter and output registers.
//  rst_n clears valid flags, stride, offset, sets both scales to 1; the font RAM
//  is not cleared and needs no sweep, so items are taken right after reset.
//  out_stall holds the output register; the pipeline backs up into in_stall.
// ----------------------------------------------------------------------------
`default_nettype none

`include "scaled_bitmap_glyph_renderer_macros.svh"

module scaled_bitmap_glyph_renderer #(
    parameter int FONT_CHARS       = sbgr_pkg::FONT_CHARS_DEF,
    parameter int MAX_X_SCALE      = sbgr_pkg::MAX_X_SCALE_DEF,
    parameter int BUFFER_ADDR_BITS = sbgr_pkg::BUFFER_ADDR_BITS_DEF
) (
    input  wire logic        clk,
    input  wire logic        rst_n,

    // configuration write port
    input  wire logic                           cfg_write,
    input  wire logic [sbgr_pkg::CFG_IDX_W-1:0] cfg_index,
    input  wire logic [sbgr_pkg::CFG_W-1:0]     cfg_data,

    // input channel
    input  wire logic        in_valid,
    output logic             in_stall,
    input  wire logic        kind,
    input  wire logic [10:0] font_address,
    input  wire logic [7:0]  font_data,
    input  wire logic [7:0]  char_code,
    input  wire logic [2:0]  glyph_row,
    input  wire logic [3:0]  copy_row,
    input  wire logic [7:0]  column,

    // output channel
    output logic             out_valid,
    input  wire logic        out_stall,
    output logic [15:0]      buffer_address,
    output logic [7:0]       pixel_byte,
    output logic             last
);

    localparam int FONT_DEPTH = FONT_CHARS * sbgr_pkg::GLYPH_ROWS;
    localparam int FONT_AW    = $clog2(FONT_DEPTH);
    localparam int ADDR_W     = BUFFER_ADDR_BITS;
    localparam int XS_W       = sbgr_pkg::XS_W;
    localparam int BASE_W     = sbgr_pkg::BASE_W;
    localparam int BYTE_W     = sbgr_pkg::FONT_BYTE_W;

    // ------------------------------------------------------------------
    // Configuration registers
    // ------------------------------------------------------------------
    logic [XS_W-1:0]                x_scale_reg;
    logic [sbgr_pkg::YS_W-1:0]      y_scale_reg;
    logic [sbgr_pkg::LINE_W-1:0]    line_stride_reg;
    logic [sbgr_pkg::LINE_W-1:0]    column_offset_reg;
    logic [XS_W-1:0]                x_scale_wr;

    // x_scale writes, cut to their low four bits, are clamped to MAX_X_SCALE
    always_comb
    begin
        x_scale_wr = cfg_data[XS_W-1:0];
        if (x_scale_wr > XS_W'(MAX_X_SCALE))
        begin
            x_scale_wr = XS_W'(MAX_X_SCALE);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            x_scale_reg       <= XS_W'(1);
            y_scale_reg       <= 5'd1;
            line_stride_reg   <= '0;
            column_offset_reg <= '0;
        end
        else if (cfg_write)
        begin
            case (cfg_index)
                sbgr_pkg::CFG_X_SCALE:       x_scale_reg       <= x_scale_wr;
                sbgr_pkg::CFG_Y_SCALE:       y_scale_reg       <= cfg_data[4:0];
                sbgr_pkg::CFG_LINE_STRIDE:   line_stride_reg   <= cfg_data;
                sbgr_pkg::CFG_COLUMN_OFFSET: column_offset_reg <= cfg_data;
                default:                     ;
            endcase
        end
    end

    // ------------------------------------------------------------------
    // Pipeline handshake
    //   s1: font RAM read in flight, small products
    //   s2: glyph byte captured, base address
    //   e : byte emitter (one byte per unstalled cycle into the output register)
    // ------------------------------------------------------------------
    logic s1_valid_reg, s1_valid_next;
    logic s2_valid_reg, s2_valid_next;
    logic e_valid_reg,  e_valid_next;
    logic out_valid_reg, out_valid_next;

    logic out_free, e_emit, e_last, e_take;
    logic s2_take, s2_move, s1_move;
    logic in_acc, render_ok, load_ok;

    assign out_free = !out_valid_reg || !out_stall;
    assign e_emit   = e_valid_reg && out_free;
    assign e_take   = !e_valid_reg || (e_emit && e_last);
    assign s2_move  = s2_valid_reg && e_take;
    assign s2_take  = !s2_valid_reg || s2_move;
    assign s1_move  = s1_valid_reg && s2_take;
    assign in_stall = s1_valid_reg && !s1_move;
    assign in_acc   = in_valid && !in_stall;

    // a copy index at or above y_scale, or a zero x_scale, yields nothing
    assign render_ok = in_acc && (kind == sbgr_pkg::KIND_RENDER)
                    && ({1'b0, copy_row} < y_scale_reg)
                    && (x_scale_reg != '0);
    assign load_ok   = in_acc && (kind == sbgr_pkg::KIND_LOAD)
                    && ({1'b0, font_address} < 12'(FONT_DEPTH));

    // ------------------------------------------------------------------
    // Font memory. Loads write at accept, renders read at accept; only one
    // transaction is accepted per cycle, so accesses never collide.
    // ------------------------------------------------------------------
    logic [FONT_AW-1:0] ram_addr;
    logic [BYTE_W-1:0]  ram_rdata;
    logic [10:0]        render_addr;

    assign render_addr = {char_code, glyph_row};
    assign ram_addr    = (kind == sbgr_pkg::KIND_LOAD) ? font_address[FONT_AW-1:0]
                                                       : render_addr[FONT_AW-1:0];

    sbgr_ram #(
        .WIDTH (BYTE_W),
        .DEPTH (FONT_DEPTH)
    ) u_font_ram (
        .clk   (clk),
        .we    (load_ok),
        .re    (render_ok),
        .addr  (ram_addr),
        .wdata (font_data),
        .rdata (ram_rdata)
    );

    // ------------------------------------------------------------------
    // Stage 1
    // ------------------------------------------------------------------
    logic [sbgr_pkg::LINE_IDX_W-1:0] s1_line_reg;
    logic [sbgr_pkg::COL_TERM_W-1:0] s1_col_reg;
    logic                            s1_char_ok_reg;

    always_comb
    begin
        s1_valid_next = s1_valid_reg;
        if (render_ok)
        begin
            s1_valid_next = 1'b1;
        end
        else if (s1_move)
        begin
            s1_valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (render_ok)
        begin
            s1_line_reg    <= 8'({5'b0, glyph_row} * {3'b0, y_scale_reg})
                            + {4'b0, copy_row};
            s1_col_reg     <= {4'b0, column} * {8'b0, x_scale_reg};
            s1_char_ok_reg <= ({1'b0, char_code} < 9'(FONT_CHARS));
        end
    end

    // ------------------------------------------------------------------
    // Stage 2: base = line*line_stride + column_offset + column*x_scale
    // ------------------------------------------------------------------
    logic [BASE_W-1:0]        s2_base;
    logic [ADDR_W+BASE_W-1:0] s2_base_ext;
    logic [ADDR_W-1:0]        s2_addr_reg;
    logic [BYTE_W-1:0]        s2_glyph_reg;

    assign s2_base = BASE_W'({10'b0, s1_line_reg} * {8'b0, line_stride_reg})
                   + {9'b0, column_offset_reg}
                   + {7'b0, s1_col_reg};
    assign s2_base_ext = {{ADDR_W{1'b0}}, s2_base};

    always_comb
    begin
        s2_valid_next = s2_valid_reg;
        if (s1_move)
        begin
            s2_valid_next = 1'b1;
        end
        else if (s2_move)
        begin
            s2_valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (s1_move)
        begin
            s2_addr_reg  <= s2_base_ext[ADDR_W-1:0];
            s2_glyph_reg <= s1_char_ok_reg ? ram_rdata : '0;
        end
    end

    // ------------------------------------------------------------------
    // Byte emitter. Walks the stretched bits eight per unstalled cycle:
    // src is the source bit from the left, rep how often it has been used.
    // ------------------------------------------------------------------
    logic [ADDR_W-1:0] e_addr_reg;
    logic [BYTE_W-1:0] e_glyph_reg;
    logic [XS_W-1:0]   e_cnt_reg;
    logic [2:0]        e_src_reg;
    logic [XS_W-1:0]   e_rep_reg;

    logic [2:0]        st_src;
    logic [XS_W-1:0]   st_rep;
    logic [BYTE_W-1:0] st_byte;

    always_comb
    begin
        st_src  = e_src_reg;
        st_rep  = e_rep_reg;
        st_byte = '0;
        for (int j = 0; j < BYTE_W; j++)
        begin
            st_byte = {st_byte[BYTE_W-2:0], e_glyph_reg[~st_src]};
            if (st_rep + XS_W'(1) == x_scale_reg)
            begin
                st_rep = '0;
                st_src = st_src + 3'd1;
            end
            else
            begin
                st_rep = st_rep + XS_W'(1);
            end
        end
    end

    assign e_last = (e_cnt_reg + XS_W'(1)) == x_scale_reg;

    always_comb
    begin
        e_valid_next = e_valid_reg;
        if (s2_move)
        begin
            e_valid_next = 1'b1;
        end
        else if (e_emit && e_last)
        begin
            e_valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (s2_move)
        begin
            e_addr_reg  <= s2_addr_reg;
            e_glyph_reg <= s2_glyph_reg;
            e_cnt_reg   <= '0;
            e_src_reg   <= '0;
            e_rep_reg   <= '0;
        end
        else if (e_emit)
        begin
            e_addr_reg <= e_addr_reg + ADDR_W'(1);
            e_cnt_reg  <= e_cnt_reg + XS_W'(1);
            e_src_reg  <= st_src;
            e_rep_reg  <= st_rep;
        end
    end

    // ------------------------------------------------------------------
    // Output register
    // ------------------------------------------------------------------
    logic [ADDR_W-1:0]                      out_addr_reg;
    logic [BYTE_W-1:0]                      out_byte_reg;
    logic                                   out_last_reg;
    logic [ADDR_W+sbgr_pkg::OUT_ADDR_W-1:0] out_addr_ext;

    always_comb
    begin
        out_valid_next = out_valid_reg;
        if (e_emit)
        begin
            out_valid_next = 1'b1;
        end
        else if (!out_stall)
        begin
            out_valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (e_emit)
        begin
            out_addr_reg <= e_addr_reg;
            out_byte_reg <= st_byte;
            out_last_reg <= e_last;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg  <= 1'b0;
            s2_valid_reg  <= 1'b0;
            e_valid_reg   <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            s1_valid_reg  <= s1_valid_next;
            s2_valid_reg  <= s2_valid_next;
            e_valid_reg   <= e_valid_next;
            out_valid_reg <= out_valid_next;
        end
    end

    // buffer address keeps the low 16 bits of the wrapped address
    assign out_addr_ext   = {{sbgr_pkg::OUT_ADDR_W{1'b0}}, out_addr_reg};
    assign buffer_address = out_addr_ext[sbgr_pkg::OUT_ADDR_W-1:0];
    assign pixel_byte     = out_byte_reg;
    assign last           = out_last_reg;
    assign out_valid      = out_valid_reg;

    // ------------------------------------------------------------------
    // Assertions
    // ------------------------------------------------------------------
    `SBGR_ASSERT_IMP(a_cnt_in_range, clk, rst_n, e_valid_reg, e_cnt_reg < x_scale_reg)
    `SBGR_ASSERT_IMP(a_rep_in_range, clk, rst_n, e_valid_reg, e_rep_reg < x_scale_reg)
    `SBGR_ASSERT_NXT(a_s1_to_s2, clk, rst_n, s1_move, s2_valid_reg)
    `SBGR_ASSERT_NXT(a_drop_copy, clk, rst_n, in_acc && kind == sbgr_pkg::KIND_RENDER && {1'b0, copy_row} >= y_scale_reg, !s1_valid_reg)

endmodule

`default_nettype wire
